FILE: hdl/gma_pkg.sv
`default_nettype none

package gma_pkg;

    localparam int MAX_COMMUNITIES_DEFAULT = 1024;
    localparam int COUNT_WIDTH_DEFAULT     = 32;
    localparam int FRACTION_BITS_DEFAULT   = 16;

    localparam int COMM_WIDTH    = 10;
    localparam int CFG_WIDTH     = 11;
    localparam int ENTRY_WIDTH   = 32;
    localparam int STATUS_WIDTH  = 2;
    localparam int S_TDATA_WIDTH = ((2 * COMM_WIDTH + 7) / 8) * 8;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 11'd1024;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_FINISH     = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_SATURATED = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_PREP,
        ST_SCALE,
        ST_DIVIDE,
        ST_DONE
    } fin_state_t;

    typedef struct packed {
        logic accept_ok;
        logic owns_mem;
    } fin_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/graph_modularity_accumulator.sv
`default_nettype none

// Newman-Girvan modularity of a streamed partition. Edge transactions (s_tuser = 0) carry the
// owner and neighbor community of one adjacency entry and are taken one per cycle while s_tready
// is high: the per-community degree and internal counts live in one table memory that is updated
// by a read-modify-write with forwarding from the write-back stage. A finish transaction
// (s_tuser = 1) sweeps the whole table once (one row per cycle through the single read port,
// clearing each row as it goes), then divides, one quotient bit per cycle, before the result
// is offered on m_*; s_tready is low meanwhile. Edge transactions are taken again while that
// result waits on m_tready. After reset a clearing pass over every row runs with s_tready low.
// Counters saturate at 2^COUNT_WIDTH-1 and then report status 2; an empty graph reports
// status 1 with Q = 0.
module graph_modularity_accumulator #(
    parameter int MAX_COMMUNITIES = gma_pkg::MAX_COMMUNITIES_DEFAULT,
    parameter int COUNT_WIDTH     = gma_pkg::COUNT_WIDTH_DEFAULT,
    parameter int FRACTION_BITS   = gma_pkg::FRACTION_BITS_DEFAULT,
    localparam int Q_W           = FRACTION_BITS + 2,
    localparam int M_TDATA_WIDTH = ((Q_W + gma_pkg::ENTRY_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [gma_pkg::CFG_WIDTH-1:0]       cfg_wdata,     // summed community count
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // node_community [9:0], neighbor_community [19:10]
    input  wire logic [gma_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    input  wire logic [0:0]                          s_tuser,       // command
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // q_scaled [Q_W-1:0], entry_total [Q_W+31:Q_W]
    output logic      [M_TDATA_WIDTH-1:0]            m_tdata,
    output logic      [gma_pkg::STATUS_WIDTH-1:0]    m_tuser        // status
);

    localparam int IDX_W = $clog2(MAX_COMMUNITIES);
    localparam int ROW_W = 2 * COUNT_WIDTH;

    logic [gma_pkg::CFG_WIDTH-1:0]    num_comm_reg;
    logic                             s_accept;
    logic                             acc_item;
    logic                             fin_start;
    gma_pkg::fin_ctrl_t               fin_ctrl;
    logic [IDX_W-1:0]                 acc_rd_addr;
    logic                             acc_wr_en;
    logic [IDX_W-1:0]                 acc_wr_addr;
    logic [ROW_W-1:0]                 acc_wr_data;
    logic [COUNT_WIDTH-1:0]           entry_count;
    logic                             overflow;
    logic [IDX_W-1:0]                 sweep_addr;
    logic                             sweep_wr_en;
    logic [IDX_W-1:0]                 mem_rd_addr;
    logic                             mem_wr_en;
    logic [IDX_W-1:0]                 mem_wr_addr;
    logic [ROW_W-1:0]                 mem_wr_data;
    logic [ROW_W-1:0]                 mem_rd_data;
    logic signed [Q_W-1:0]            q_scaled;
    logic [gma_pkg::ENTRY_WIDTH-1:0]  entry_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_comm_reg <= gma_pkg::CFG_RESET;
        end else if (cfg_we) begin
            num_comm_reg <= cfg_wdata;
        end
    end

    assign s_tready  = fin_ctrl.accept_ok;
    assign s_accept  = s_tvalid && s_tready;
    assign acc_item  = s_accept && s_tuser[0] == gma_pkg::CMD_ACCUMULATE;
    assign fin_start = s_accept && s_tuser[0] == gma_pkg::CMD_FINISH;

    gma_accum #(
        .MAX_COMMUNITIES (MAX_COMMUNITIES),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (acc_item),
        .node_comm   (s_tdata[gma_pkg::COMM_WIDTH-1:0]),
        .nbr_comm    (s_tdata[2*gma_pkg::COMM_WIDTH-1:gma_pkg::COMM_WIDTH]),
        .clear       (fin_start),
        .rd_addr     (acc_rd_addr),
        .rd_data     (mem_rd_data),
        .wr_en       (acc_wr_en),
        .wr_addr     (acc_wr_addr),
        .wr_data     (acc_wr_data),
        .entry_count (entry_count),
        .overflow    (overflow)
    );

    // the sweep reads and zeroes the same row in the same cycle
    assign mem_rd_addr = fin_ctrl.owns_mem ? sweep_addr  : acc_rd_addr;
    assign mem_wr_en   = fin_ctrl.owns_mem ? sweep_wr_en : acc_wr_en;
    assign mem_wr_addr = fin_ctrl.owns_mem ? sweep_addr  : acc_wr_addr;
    assign mem_wr_data = fin_ctrl.owns_mem ? '0          : acc_wr_data;

    gma_table_mem #(
        .DEPTH  (MAX_COMMUNITIES),
        .DATA_W (ROW_W)
    ) u_table (
        .aclk    (aclk),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    gma_finish #(
        .MAX_COMMUNITIES (MAX_COMMUNITIES),
        .COUNT_WIDTH     (COUNT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_finish (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (fin_start),
        .k_in        (entry_count),
        .ovf_in      (overflow),
        .num_comm    (num_comm_reg),
        .ctrl        (fin_ctrl),
        .sweep_addr  (sweep_addr),
        .sweep_wr_en (sweep_wr_en),
        .rd_data     (mem_rd_data),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .q_scaled    (q_scaled),
        .entry_total (entry_total),
        .status      (m_tuser)
    );

    assign m_tdata = M_TDATA_WIDTH'({entry_total, q_scaled});

endmodule

`default_nettype wire

FILE: hdl/gma_table_mem.sv
`default_nettype none

module gma_table_mem #(
    parameter int DEPTH  = gma_pkg::MAX_COMMUNITIES_DEFAULT,
    parameter int DATA_W = 2 * gma_pkg::COUNT_WIDTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/gma_accum.sv
`default_nettype none

module gma_accum #(
    parameter int MAX_COMMUNITIES = gma_pkg::MAX_COMMUNITIES_DEFAULT,
    parameter int COUNT_WIDTH     = gma_pkg::COUNT_WIDTH_DEFAULT,
    localparam int IDX_W = $clog2(MAX_COMMUNITIES),
    localparam int ROW_W = 2 * COUNT_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            item_valid,
    input  wire logic [gma_pkg::COMM_WIDTH-1:0]  node_comm,
    input  wire logic [gma_pkg::COMM_WIDTH-1:0]  nbr_comm,
    input  wire logic                            clear,
    output logic      [IDX_W-1:0]                rd_addr,
    input  wire logic [ROW_W-1:0]                rd_data,
    output logic                                 wr_en,
    output logic      [IDX_W-1:0]                wr_addr,
    output logic      [ROW_W-1:0]                wr_data,
    output logic      [COUNT_WIDTH-1:0]          entry_count,
    output logic                                 overflow
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   in_range;
    logic                   s2_valid_reg;
    logic                   s2_match_reg;
    logic [IDX_W-1:0]       s2_addr_reg;
    logic                   fwd_valid_reg;
    logic [IDX_W-1:0]       fwd_addr_reg;
    logic [ROW_W-1:0]       fwd_data_reg;
    logic [ROW_W-1:0]       row;
    logic [COUNT_WIDTH-1:0] deg;
    logic [COUNT_WIDTH-1:0] intl;
    logic [COUNT_WIDTH-1:0] deg_new;
    logic [COUNT_WIDTH-1:0] intl_new;
    logic                   deg_sat;
    logic                   intl_sat;
    logic                   row_sat;
    logic                   entry_sat;
    logic [COUNT_WIDTH-1:0] entry_count_reg;
    logic                   overflow_reg;

    assign in_range = 32'(node_comm) < 32'(MAX_COMMUNITIES);
    assign rd_addr  = IDX_W'(node_comm);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= item_valid && in_range;
            fwd_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_addr_reg  <= rd_addr;
        s2_match_reg <= node_comm == nbr_comm;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= wr_data;
    end

    // the row written last cycle is not yet visible in the read data
    always_comb begin
        row      = (fwd_valid_reg && fwd_addr_reg == s2_addr_reg) ? fwd_data_reg : rd_data;
        deg      = row[COUNT_WIDTH-1:0];
        intl     = row[ROW_W-1:COUNT_WIDTH];
        deg_sat  = deg == COUNT_MAX;
        intl_sat = s2_match_reg && intl == COUNT_MAX;
        deg_new  = deg_sat ? deg : deg + COUNT_WIDTH'(1);
        intl_new = (s2_match_reg && !intl_sat) ? intl + COUNT_WIDTH'(1) : intl;
        row_sat  = s2_valid_reg && (deg_sat || intl_sat);
    end

    assign wr_en   = s2_valid_reg;
    assign wr_addr = s2_addr_reg;
    assign wr_data = {intl_new, deg_new};

    assign entry_sat = entry_count_reg == COUNT_MAX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end else if (clear) begin
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end else begin
            if (item_valid && !entry_sat) begin
                entry_count_reg <= entry_count_reg + COUNT_WIDTH'(1);
            end
            if (row_sat || (item_valid && entry_sat)) begin
                overflow_reg <= 1'b1;
            end
        end
    end

    assign entry_count = entry_count_reg;
    // include a saturation still sitting in the write-back stage
    assign overflow    = overflow_reg | row_sat;

endmodule

`default_nettype wire

FILE: hdl/gma_finish.sv
`default_nettype none

module gma_finish #(
    parameter int MAX_COMMUNITIES = gma_pkg::MAX_COMMUNITIES_DEFAULT,
    parameter int COUNT_WIDTH     = gma_pkg::COUNT_WIDTH_DEFAULT,
    parameter int FRACTION_BITS   = gma_pkg::FRACTION_BITS_DEFAULT,
    localparam int IDX_W = $clog2(MAX_COMMUNITIES),
    localparam int ROW_W = 2 * COUNT_WIDTH,
    localparam int Q_W   = FRACTION_BITS + 2
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [COUNT_WIDTH-1:0]            k_in,
    input  wire logic                              ovf_in,
    input  wire logic [gma_pkg::CFG_WIDTH-1:0]     num_comm,
    output gma_pkg::fin_ctrl_t                     ctrl,
    output logic      [IDX_W-1:0]                  sweep_addr,
    output logic                                   sweep_wr_en,
    input  wire logic [ROW_W-1:0]                  rd_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [Q_W-1:0]                  q_scaled,
    output logic      [gma_pkg::ENTRY_WIDTH-1:0]   entry_total,
    output logic      [gma_pkg::STATUS_WIDTH-1:0]  status
);

    localparam int ACC_W = 2 * COUNT_WIDTH + IDX_W;
    localparam int DSQ_W = 2 * COUNT_WIDTH;
    localparam int CNT_W = $clog2(Q_W);
    localparam int CMP_W = ((IDX_W > gma_pkg::CFG_WIDTH) ? IDX_W : gma_pkg::CFG_WIDTH) + 1;
    localparam logic [IDX_W-1:0] PTR_LAST  = IDX_W'(MAX_COMMUNITIES - 1);
    localparam logic [Q_W-1:0]   Q_NEG_LIM = {1'b1, {(Q_W - 1){1'b0}}};
    localparam logic [Q_W-1:0]   Q_POS_LIM = {1'b0, {(Q_W - 1){1'b1}}};

    gma_pkg::fin_state_t state_reg, state_next;

    logic [IDX_W-1:0]       ptr_reg;
    logic                   ptr_last;
    logic                   p1_live_reg;
    logic                   p1_use_reg;
    logic                   p2_live_reg;
    logic [COUNT_WIDTH-1:0] k_reg;
    logic                   ovf_reg;
    logic [DSQ_W-1:0]       prod_aa_reg;
    logic [DSQ_W-1:0]       prod_ke_reg;
    logic [ACC_W-1:0]       a2_acc_reg;
    logic [ACC_W-1:0]       pos_acc_reg;
    logic                   neg_reg;
    logic [ACC_W-1:0]       diff_reg;
    logic [DSQ_W-1:0]       dsq_reg;
    logic                   sat_reg;
    logic [DSQ_W-1:0]       rem_reg;
    logic [Q_W-1:0]         bits_reg;
    logic [Q_W-1:0]         quo_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   cnt_last;
    logic [DSQ_W:0]         trial;
    logic                   trial_ge;
    logic                   out_free;
    logic                   load_out;
    logic [Q_W-1:0]         q_mag;
    logic [Q_W-1:0]         q_val;
    logic [gma_pkg::STATUS_WIDTH-1:0] status_val;
    logic                   m_valid_reg;
    logic [Q_W-1:0]         q_reg;
    logic [gma_pkg::ENTRY_WIDTH-1:0]  total_reg;
    logic [gma_pkg::STATUS_WIDTH-1:0] status_reg;
    logic [COUNT_WIDTH-1:0] deg;
    logic [COUNT_WIDTH-1:0] intl;

    assign ptr_last = ptr_reg == PTR_LAST;
    assign cnt_last = cnt_reg == CNT_W'(Q_W - 1);
    assign out_free = !m_valid_reg || m_ready;
    assign deg      = rd_data[COUNT_WIDTH-1:0];
    assign intl     = rd_data[ROW_W-1:COUNT_WIDTH];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gma_pkg::ST_CLEAR: begin
                if (ptr_last) state_next = gma_pkg::ST_IDLE;
            end
            gma_pkg::ST_IDLE: begin
                if (start) state_next = gma_pkg::ST_SWEEP;
            end
            gma_pkg::ST_SWEEP: begin
                if (ptr_last) state_next = gma_pkg::ST_DRAIN;
            end
            gma_pkg::ST_DRAIN: begin
                if (!p1_live_reg && !p2_live_reg) state_next = gma_pkg::ST_PREP;
            end
            gma_pkg::ST_PREP: begin
                state_next = gma_pkg::ST_SCALE;
            end
            gma_pkg::ST_SCALE: begin
                state_next = gma_pkg::ST_DIVIDE;
            end
            gma_pkg::ST_DIVIDE: begin
                if (cnt_last) state_next = gma_pkg::ST_DONE;
            end
            gma_pkg::ST_DONE: begin
                if (out_free) state_next = gma_pkg::ST_IDLE;
            end
            default: begin
                state_next = gma_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        ctrl.accept_ok = 1'b0;
        ctrl.owns_mem  = 1'b0;
        sweep_wr_en    = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            gma_pkg::ST_IDLE: begin
                ctrl.accept_ok = 1'b1;
            end
            gma_pkg::ST_CLEAR, gma_pkg::ST_SWEEP: begin
                ctrl.owns_mem = 1'b1;
                sweep_wr_en   = 1'b1;
            end
            gma_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    assign sweep_addr = ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gma_pkg::ST_CLEAR;
            ptr_reg     <= '0;
            p1_live_reg <= 1'b0;
            p2_live_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == gma_pkg::ST_CLEAR || state_reg == gma_pkg::ST_SWEEP) begin
                ptr_reg <= ptr_last ? '0 : ptr_reg + IDX_W'(1);
            end
            p1_live_reg <= state_reg == gma_pkg::ST_SWEEP;
            p2_live_reg <= p1_live_reg;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sweep: read row, square and scale, then sum; rows past the register are not summed
    always_ff @(posedge aclk) begin
        p1_use_reg  <= CMP_W'(ptr_reg) < CMP_W'(num_comm);
        prod_aa_reg <= p1_use_reg ? DSQ_W'(deg) * DSQ_W'(deg) : '0;
        prod_ke_reg <= p1_use_reg ? DSQ_W'(k_reg) * DSQ_W'(intl) : '0;
        if (start) begin
            k_reg       <= k_in;
            ovf_reg     <= ovf_in;
            a2_acc_reg  <= '0;
            pos_acc_reg <= '0;
        end else if (p2_live_reg) begin
            a2_acc_reg  <= a2_acc_reg + ACC_W'(prod_aa_reg);
            pos_acc_reg <= pos_acc_reg + ACC_W'(prod_ke_reg);
        end
    end

    assign trial    = {rem_reg, bits_reg[Q_W-1]};
    assign trial_ge = trial >= {1'b0, dsq_reg};

    // quotient = (diff << FRACTION_BITS) / K^2, one bit per divide step after the top part is checked
    always_ff @(posedge aclk) begin
        case (state_reg)
            gma_pkg::ST_PREP: begin
                neg_reg  <= pos_acc_reg < a2_acc_reg;
                diff_reg <= (pos_acc_reg < a2_acc_reg) ? a2_acc_reg - pos_acc_reg
                                                       : pos_acc_reg - a2_acc_reg;
                dsq_reg  <= DSQ_W'(k_reg) * DSQ_W'(k_reg);
            end
            gma_pkg::ST_SCALE: begin
                sat_reg  <= (diff_reg >> 2) >= ACC_W'(dsq_reg);
                rem_reg  <= DSQ_W'(diff_reg >> 2);
                bits_reg <= {diff_reg[1:0], {FRACTION_BITS{1'b0}}};
                cnt_reg  <= '0;
            end
            gma_pkg::ST_DIVIDE: begin
                rem_reg  <= trial_ge ? DSQ_W'(trial - {1'b0, dsq_reg}) : DSQ_W'(trial);
                quo_reg  <= {quo_reg[Q_W-2:0], trial_ge};
                bits_reg <= {bits_reg[Q_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_comb begin
        if (neg_reg) begin
            q_mag = (sat_reg || quo_reg > Q_NEG_LIM) ? Q_NEG_LIM : quo_reg;
            q_val = Q_W'(0) - q_mag;
        end else begin
            q_mag = (sat_reg || quo_reg[Q_W-1]) ? Q_POS_LIM : quo_reg;
            q_val = q_mag;
        end
        if (k_reg == '0) begin
            q_val      = '0;
            status_val = gma_pkg::STATUS_EMPTY;
        end else begin
            status_val = ovf_reg ? gma_pkg::STATUS_SATURATED : gma_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            q_reg      <= q_val;
            total_reg  <= gma_pkg::ENTRY_WIDTH'(k_reg);
            status_reg <= status_val;
        end
    end

    assign m_valid     = m_valid_reg;
    assign q_scaled    = q_reg;
    assign entry_total = total_reg;
    assign status      = status_reg;

    a_mem_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.accept_ok && ctrl.owns_mem))
        else $error("item accepted while the sweep owns the table");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == gma_pkg::ST_IDLE)
        else $error("finish started outside idle");

    a_start_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg == gma_pkg::ST_SWEEP && ptr_reg == '0))
        else $error("sweep did not start at row zero");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gma_pkg::ST_PREP |-> (!p1_live_reg && !p2_live_reg))
        else $error("sums taken before the sweep pipeline drained");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == gma_pkg::ST_DONE)
        else $error("result appeared without a finished division");

endmodule

`default_nettype wire

FILE: bench/modularity_checker.sv
module modularity_checker #(
    parameter int Q_W       = gma_pkg::FRACTION_BITS_DEFAULT + 2,
    parameter int M_TDATA_W = ((Q_W + gma_pkg::ENTRY_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [gma_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [gma_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    input  wire logic [0:0]                          s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [M_TDATA_W-1:0]                m_tdata,
    input  wire logic [gma_pkg::STATUS_WIDTH-1:0]    m_tuser,
    output int                                       error_count,
    output int                                       pending_count,
    output int                                       results_checked
);
    import gma_pkg::*;

    localparam int MAX_COMM = MAX_COMMUNITIES_DEFAULT;
    localparam int COUNT_W  = COUNT_WIDTH_DEFAULT;
    localparam int FRAC     = FRACTION_BITS_DEFAULT;

    localparam logic [127:0] Q_POS_LIMIT = (128'd1 << (Q_W - 1)) - 128'd1;
    localparam logic [127:0] Q_NEG_LIMIT = 128'd1 << (Q_W - 1);

    typedef struct packed {
        logic [Q_W-1:0]          q_scaled;
        logic [ENTRY_WIDTH-1:0]  entry_total;
        logic [STATUS_WIDTH-1:0] status;
    } modularity_result_t;

    logic [COUNT_W-1:0]   degree_tally [MAX_COMM];
    logic [COUNT_W-1:0]   internal_tally [MAX_COMM];
    logic [COUNT_W-1:0]   entry_tally;
    logic                 tally_overflow;
    logic [CFG_WIDTH-1:0] community_limit;

    modularity_result_t expected_results [$];
    modularity_result_t want_result;
    modularity_result_t got_result;
    int                 mismatch_total = 0;
    int                 checked_total  = 0;

    function automatic void clear_tallies();
        int c;
        for (c = 0; c < MAX_COMM; c++) begin
            degree_tally[c]   = '0;
            internal_tally[c] = '0;
        end
        entry_tally    = '0;
        tally_overflow = 1'b0;
    endfunction

    // counters stick at all ones and remember that they did
    function automatic logic [COUNT_W-1:0] saturating_inc(input logic [COUNT_W-1:0] count);
        if (count == '1) begin
            tally_overflow = 1'b1;
            return count;
        end
        return count + 1'b1;
    endfunction

    function automatic void tally_entry(input logic [COMM_WIDTH-1:0] owner,
                                        input logic [COMM_WIDTH-1:0] neighbor);
        entry_tally = saturating_inc(entry_tally);
        if (int'(owner) < MAX_COMM) begin
            degree_tally[owner] = saturating_inc(degree_tally[owner]);
            if (owner == neighbor)
                internal_tally[owner] = saturating_inc(internal_tally[owner]);
        end
    endfunction

    // Q * 2^FRAC = (K*sum(e) - sum(a^2)) * 2^FRAC / K^2, truncated toward zero
    function automatic modularity_result_t modularity_of_tallies();
        modularity_result_t r;
        logic [127:0] sum_e, sum_a2, pos, num, quo, qmag, neg_q, k_sq;
        int           span, c;
        logic         negative;
        r.q_scaled    = '0;
        r.entry_total = ENTRY_WIDTH'(entry_tally);
        if (entry_tally == '0) begin
            r.status = STATUS_EMPTY;
        end else begin
            r.status = tally_overflow ? STATUS_SATURATED : STATUS_OK;
            span     = (int'(community_limit) > MAX_COMM) ? MAX_COMM : int'(community_limit);
            sum_e    = '0;
            sum_a2   = '0;
            for (c = 0; c < span; c++) begin
                sum_e  = sum_e + 128'(internal_tally[c]);
                sum_a2 = sum_a2 + 128'(degree_tally[c]) * 128'(degree_tally[c]);
            end
            pos      = 128'(entry_tally) * sum_e;
            negative = pos < sum_a2;
            num      = negative ? (sum_a2 - pos) : (pos - sum_a2);
            num      = num << FRAC;
            k_sq     = 128'(entry_tally) * 128'(entry_tally);
            quo      = num / k_sq;
            if (negative) begin
                qmag       = (quo > Q_NEG_LIMIT) ? Q_NEG_LIMIT : quo;
                neg_q      = 128'd0 - qmag;
                r.q_scaled = neg_q[Q_W-1:0];
            end else begin
                qmag       = (quo > Q_POS_LIMIT) ? Q_POS_LIMIT : quo;
                r.q_scaled = qmag[Q_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_tallies();
            community_limit = CFG_RESET;
            expected_results.delete();
        end else begin
            if (cfg_we)
                community_limit = cfg_wdata;

            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_FINISH) begin
                    expected_results.push_back(modularity_of_tallies());
                    clear_tallies();
                end else begin
                    tally_entry(s_tdata[COMM_WIDTH-1:0], s_tdata[2*COMM_WIDTH-1:COMM_WIDTH]);
                end
            end

            if (m_tvalid && m_tready) begin
                got_result.q_scaled    = m_tdata[Q_W-1:0];
                got_result.entry_total = m_tdata[Q_W+ENTRY_WIDTH-1:Q_W];
                got_result.status      = m_tuser;
                if (expected_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: stray result, expected none, actual q %0d total %0d status %0d",
                             $time, $signed(got_result.q_scaled), got_result.entry_total,
                             got_result.status);
                end else begin
                    want_result = expected_results.pop_front();
                    checked_total++;
                    check_field("q_scaled", longint'($signed(want_result.q_scaled)),
                                longint'($signed(got_result.q_scaled)));
                    check_field("entry_total", longint'(want_result.entry_total),
                                longint'(got_result.entry_total));
                    check_field("status", longint'(want_result.status),
                                longint'(got_result.status));
                end
            end
        end
        error_count     <= mismatch_total;
        pending_count   <= expected_results.size();
        results_checked <= checked_total;
    end

endmodule

FILE: bench/tb_graph_modularity_accumulator.sv
module tb_graph_modularity_accumulator;
    import gma_pkg::*;

    localparam int Q_W           = FRACTION_BITS_DEFAULT + 2;
    localparam int M_TDATA_WIDTH = ((Q_W + ENTRY_WIDTH + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 5000;
    localparam int CYCLE_LIMIT   = 8000000;
    localparam int PHASE_ITEMS   = 170;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_BURSTY
    } receive_pattern_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_WIDTH-1:0]          cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [S_TDATA_WIDTH-1:0]      s_tdata   = '0;
    logic [0:0]                    s_tuser   = CMD_ACCUMULATE;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0]      m_tdata;
    logic [STATUS_WIDTH-1:0]       m_tuser;

    int error_count;
    int pending_count;
    int results_checked;

    int unsigned sent_entries     = 0;
    int unsigned sent_finishes    = 0;
    int unsigned settings_written = 0;
    int unsigned burst_left       = 0;
    int unsigned cycle_count      = 0;
    logic        hold_request     = 1'b0;
    logic        hold_done        = 1'b0;

    graph_modularity_accumulator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    modularity_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: switches between its own ready patterns, plus one long hold-off
    initial begin : receiver
        receive_pattern_t pattern;
        int unsigned      left;
        int unsigned      run;
        logic             level;
        pattern = READY_ALWAYS;
        left    = 0;
        run     = 0;
        level   = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    pattern = receive_pattern_t'($urandom_range(0, 3));
                    left    = $urandom_range(50, 400);
                end
                left--;
                case (pattern)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
                    default: begin
                        if (run == 0) begin
                            run   = $urandom_range(1, 12);
                            level = ~level;
                        end
                        run--;
                        m_tready <= level;
                    end
                endcase
            end
        end
    end

    // offer one transaction, hold it until taken, then maybe leave a gap
    task automatic offer_entry(input logic cmd, input logic [COMM_WIDTH-1:0] owner,
                               input logic [COMM_WIDTH-1:0] neighbor);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_WIDTH - 2 * COMM_WIDTH){1'b0}}, neighbor, owner};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_FINISH)
            sent_finishes++;
        else
            sent_entries++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        // edge entries may still be in the read-modify-write pipeline
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    // small random graph, both directions of each edge unless lopsided, then finish
    task automatic send_graph(input int unsigned span);
        logic [COMM_WIDTH-1:0] pool [4];
        logic [COMM_WIDTH-1:0] node_comm [12];
        int unsigned           n_comm, n_nodes, n_edges, u, v, i;
        logic                  lopsided;
        n_comm = $urandom_range(1, 4);
        for (i = 0; i < 4; i++)
            pool[i] = ($urandom_range(0, 1) == 1) ? COMM_WIDTH'($urandom_range(0, span - 1))
                                                  : COMM_WIDTH'($urandom);
        n_nodes = $urandom_range(2, 12);
        for (i = 0; i < 12; i++)
            node_comm[i] = pool[$urandom_range(0, n_comm - 1)];
        n_edges  = $urandom_range(1, 12);
        lopsided = ($urandom_range(0, 5) == 0);
        for (i = 0; i < n_edges; i++) begin
            u = $urandom_range(0, n_nodes - 1);
            v = $urandom_range(0, n_nodes - 1);
            offer_entry(CMD_ACCUMULATE, node_comm[u], node_comm[v]);
            if (!lopsided || $urandom_range(0, 1) == 1)
                offer_entry(CMD_ACCUMULATE, node_comm[v], node_comm[u]);
        end
        offer_entry(CMD_FINISH, COMM_WIDTH'($urandom), COMM_WIDTH'($urandom));
    endtask

    task automatic random_phase(input logic [CFG_WIDTH-1:0] limit, input int unsigned budget,
                                input logic long_hold);
        int unsigned start, span, pick;
        wait_results_done();
        write_limit(limit);
        if (long_hold)
            hold_request <= 1'b1;
        span  = (limit == 0 || limit > MAX_COMMUNITIES_DEFAULT) ? MAX_COMMUNITIES_DEFAULT
                                                                : limit;
        start = sent_entries + sent_finishes;
        while (sent_entries + sent_finishes - start < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                send_graph(span);
            else if (pick == 8)
                repeat ($urandom_range(1, 5))
                    offer_entry(CMD_ACCUMULATE, COMM_WIDTH'($urandom), COMM_WIDTH'($urandom));
            else
                offer_entry(CMD_FINISH, COMM_WIDTH'($urandom), COMM_WIDTH'($urandom));
        end
        offer_entry(CMD_FINISH, COMM_WIDTH'($urandom), COMM_WIDTH'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_limit(CFG_RESET);

        // empty graph
        offer_entry(CMD_FINISH, '0, '0);
        // extreme community indices and alternating bit patterns
        offer_entry(CMD_ACCUMULATE, 10'd0, 10'd0);
        offer_entry(CMD_ACCUMULATE, 10'd1023, 10'd1023);
        offer_entry(CMD_ACCUMULATE, 10'd0, 10'd1023);
        offer_entry(CMD_ACCUMULATE, 10'd1023, 10'd0);
        offer_entry(CMD_ACCUMULATE, 10'h155, 10'h2aa);
        offer_entry(CMD_ACCUMULATE, 10'h2aa, 10'h2aa);
        offer_entry(CMD_FINISH, 10'h3ff, 10'h3ff);
        // no internal entries at all, most negative modularity
        offer_entry(CMD_ACCUMULATE, 10'd0, 10'd1);
        offer_entry(CMD_ACCUMULATE, 10'd0, 10'd1);
        offer_entry(CMD_FINISH, '0, '0);
        // two isolated communities
        offer_entry(CMD_ACCUMULATE, 10'd0, 10'd0);
        offer_entry(CMD_ACCUMULATE, 10'd1, 10'd1);
        offer_entry(CMD_FINISH, '0, '0);
        // back-to-back finish leaves an empty graph
        offer_entry(CMD_FINISH, '0, '0);

        // no community summed
        wait_results_done();
        write_limit('0);
        offer_entry(CMD_ACCUMULATE, 10'd2, 10'd2);
        offer_entry(CMD_ACCUMULATE, 10'd3, 10'd4);
        offer_entry(CMD_FINISH, '0, '0);

        // register above the table size is clipped
        wait_results_done();
        write_limit(11'd2047);
        offer_entry(CMD_ACCUMULATE, 10'd1023, 10'd1023);
        offer_entry(CMD_ACCUMULATE, 10'd1, 10'd1);
        offer_entry(CMD_ACCUMULATE, 10'd1, 10'd2);
        offer_entry(CMD_FINISH, '0, '0);

        random_phase(11'd1, PHASE_ITEMS, 1'b0);
        random_phase(11'd1025, PHASE_ITEMS, 1'b0);
        random_phase(11'd512, PHASE_ITEMS, 1'b1);
        random_phase(CFG_WIDTH'($urandom_range(2, 1023)), PHASE_ITEMS, 1'b0);
        random_phase(CFG_RESET, PHASE_ITEMS, 1'b0);
        random_phase(11'd2, PHASE_ITEMS, 1'b0);

        wait_results_done();
        $display("summary: %0d edge entries and %0d finish transactions over %0d register settings",
                 sent_entries, sent_finishes, settings_written);
        $display("summary: %0d modularity results checked, one receiver hold-off of %0d cycles",
                 results_checked, HOLD_CYCLES);
        if (error_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
